// ----- rtl/core/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// shared types, constants and lead byte classification for the utf-8 to
// 16-bit code unit decoder
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned CntW  = 3;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 1;

  localparam logic [IdxW-1:0]  CfgSwapBytes = 1'b0;
  localparam logic [IdxW-1:0]  CfgReplUnit  = 1'b1;

  localparam logic [UnitW-1:0] ReplUnitReset = 16'h003F;
  localparam logic [ByteW-1:0] TrailMask     = 8'h3F;
  localparam logic [UnitW-1:0] TwoByteMask   = 16'h07FF;

  localparam logic [CntW-1:0]  SizeNone = 3'd0;
  localparam logic [CntW-1:0]  SizeOne  = 3'd1;
  localparam logic [CntW-1:0]  SizeTwo  = 3'd2;

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             cut_short;
    logic             was_replaced;
    logic             last_unit;
  } u8u16_res_t;

  // sequence length started by a lead byte, zero when it has no class
  function automatic logic [CntW-1:0] lead_size(input logic [ByteW-1:0] b);
    logic [CntW-1:0] sz;
    sz = SizeNone;
    if (b[7] == 1'b0)                sz = 3'd1;
    else if (b[7:5] == 3'b110)       sz = 3'd2;
    else if (b[7:4] == 4'b1110)      sz = 3'd3;
    else if (b[7:3] == 5'b11110)     sz = 3'd4;
    else if (b[7:2] == 6'b111110)    sz = 3'd5;
    else if (b[7:1] == 7'b1111110)   sz = 3'd6;
    return sz;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/u8u16_in_stage.sv -----
// ----------------------------------------------------------------------------
// u8u16_in_stage
// input register for one byte item and its end-of-text mark
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_in_stage (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic [u8u16_pkg::ByteW-1:0]  byte_i,
  input  wire logic                         eot_i,
  output logic                              valid_o,
  input  wire logic                         take_i,
  output logic [u8u16_pkg::ByteW-1:0]       byte_o,
  output logic                              eot_o
);

  logic                        valid_q;
  logic [u8u16_pkg::ByteW-1:0] byte_q;
  logic                        eot_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign eot_o   = eot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
      eot_q  <= eot_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/u8u16_core.sv -----
// ----------------------------------------------------------------------------
// u8u16_core
// sequence state and one-byte decode step
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [u8u16_pkg::ByteW-1:0]  byte_i,
  input  wire logic                         eot_i,
  input  wire logic                         push_ready_i,
  input  wire logic                         swap_i,
  input  wire logic [u8u16_pkg::UnitW-1:0]  repl_i,
  output logic                              take_o,
  output logic                              push_o,
  output u8u16_pkg::u8u16_res_t             res_o
);

  logic [u8u16_pkg::UnitW-1:0] acc_q, acc_d;
  logic [u8u16_pkg::CntW-1:0]  rem_q, rem_d;
  logic [u8u16_pkg::CntW-1:0]  size_q, size_d;
  logic [u8u16_pkg::CntW-1:0]  lead;
  logic [u8u16_pkg::CntW-1:0]  rem_dec;
  logic [u8u16_pkg::UnitW-1:0] acc_shift;
  logic [u8u16_pkg::UnitW-1:0] unit;
  logic                        emit;
  logic                        repl;
  logic                        cut;

  assign take_o    = valid_i && push_ready_i;
  assign lead      = u8u16_pkg::lead_size(byte_i);
  assign rem_dec   = rem_q - 3'd1;
  assign acc_shift = {acc_q[u8u16_pkg::UnitW-7:0], byte_i[5:0] & u8u16_pkg::TrailMask[5:0]};

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    size_d = size_q;
    emit   = 1'b0;
    repl   = 1'b0;
    cut    = 1'b0;
    unit   = '0;
    if (rem_q == '0) begin
      if (lead == u8u16_pkg::SizeNone) begin
        emit = 1'b1;
        repl = 1'b1;
        unit = repl_i;
      end else if (lead == u8u16_pkg::SizeOne) begin
        emit = 1'b1;
        unit = {8'h00, byte_i};
      end else if (eot_i) begin
        emit   = 1'b1;
        cut    = 1'b1;
        acc_d  = '0;
        size_d = '0;
      end else begin
        acc_d  = {8'h00, byte_i};
        size_d = lead;
        rem_d  = lead - 3'd1;
      end
    end else if (rem_dec == '0) begin
      emit   = 1'b1;
      unit   = (size_q == u8u16_pkg::SizeTwo) ? (acc_shift & u8u16_pkg::TwoByteMask)
                                              : acc_shift;
      acc_d  = '0;
      rem_d  = '0;
      size_d = '0;
    end else if (eot_i) begin
      emit   = 1'b1;
      cut    = 1'b1;
      acc_d  = '0;
      rem_d  = '0;
      size_d = '0;
    end else begin
      acc_d = acc_shift;
      rem_d = rem_dec;
    end
  end

  assign push_o             = take_o && emit;
  assign res_o.unit         = swap_i ? {unit[7:0], unit[15:8]} : unit;
  assign res_o.was_replaced = repl;
  assign res_o.cut_short    = cut;
  assign res_o.last_unit    = cut || eot_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      size_q <= '0;
    end else if (take_o) begin
      acc_q  <= acc_d;
      rem_q  <= rem_d;
      size_q <= size_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/u8u16_out_stage.sv -----
// ----------------------------------------------------------------------------
// u8u16_out_stage
// result register with a skid entry so the decoder keeps running while one
// result waits, and stalls only once a second result fills the skid entry
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_out_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire u8u16_pkg::u8u16_res_t res_i,
  output logic                       ready_o,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output u8u16_pkg::u8u16_res_t      res_o
);

  logic                  out_valid_q;
  logic                  skd_valid_q;
  u8u16_pkg::u8u16_res_t out_q;
  u8u16_pkg::u8u16_res_t skd_q;
  logic                  slot_free;

  assign ready_o   = !skd_valid_q;
  assign valid_o   = out_valid_q;
  assign res_o     = out_q;
  assign slot_free = !out_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skd_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= skd_valid_q || push_i;
      skd_valid_q <= 1'b0;
    end else if (push_i) begin
      skd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      out_q <= skd_valid_q ? skd_q : res_i;
    end else if (push_i) begin
      skd_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/utf8_to_utf16_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit
// utf-8 byte stream to 16-bit code units, while m_axis takes results one byte item per cycle
// ----------------------------------------------------------------------------
// path: an accepted byte item passes the input register and the result register on its way to m_axis
// throughput: 1 byte item per cycle while m_axis takes results, set by the single decode step between
//   the input register and the result register
// reset: no sequence open, swap off, replacement unit 0x003f, both
//   registers empty
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_decoder_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // byte_in
  input  wire logic                        s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // code_unit
  output logic [1:0]                       m_axis_tuser,  // cut_short, was_replaced
  output logic                             m_axis_tlast,
  input  wire logic                        cfg_we_i,
  input  wire logic [u8u16_pkg::IdxW-1:0]  cfg_idx_i,
  input  wire logic [u8u16_pkg::CfgW-1:0]  cfg_data_i
);

  logic                        swap_q;
  logic [u8u16_pkg::UnitW-1:0] repl_q;

  logic                        in_valid;
  logic [u8u16_pkg::ByteW-1:0] in_byte;
  logic                        in_eot;
  logic                        take;
  logic                        push;
  logic                        push_ready;
  u8u16_pkg::u8u16_res_t       res;
  u8u16_pkg::u8u16_res_t       out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b0;
      repl_q <= u8u16_pkg::ReplUnitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        u8u16_pkg::CfgSwapBytes: swap_q <= cfg_data_i[0];
        u8u16_pkg::CfgReplUnit:  repl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  u8u16_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .eot_i   (s_axis_tlast),
    .valid_o (in_valid),
    .take_i  (take),
    .byte_o  (in_byte),
    .eot_o   (in_eot)
  );

  u8u16_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid),
    .byte_i       (in_byte),
    .eot_i        (in_eot),
    .push_ready_i (push_ready),
    .swap_i       (swap_q),
    .repl_i       (repl_q),
    .take_o       (take),
    .push_o       (push),
    .res_o        (res)
  );

  u8u16_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .ready_o (push_ready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = out_res.unit;
  assign m_axis_tuser = {out_res.cut_short, out_res.was_replaced};
  assign m_axis_tlast = out_res.last_unit;

  // input side stalls only when a result is held on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
    else $error("cut short result not marked last or marked replaced");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> take)
    else $error("result pushed without consuming a byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res.cut_short |=> !push || !res.cut_short || $past(in_eot))
    else $error("cut short without end of text");

endmodule

`default_nettype wire

// ----- dv/u8u16_unit_checker.sv -----
// ----------------------------------------------------------------------------
// u8u16_unit_checker
// watches the byte, unit and register channels of the utf-8 decoder, keeps
// its own decode state, predicts every code unit and compares each field of
// the accepted results in order
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_unit_checker
  import u8u16_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_ready_i,
  input  wire logic [7:0]       in_data_i,   // byte_in
  input  wire logic             in_last_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_ready_i,
  input  wire logic [15:0]      out_data_i,  // code_unit
  input  wire logic [1:0]       out_user_i,  // cut_short, was_replaced
  input  wire logic             out_last_i,
  input  wire logic             cfg_we_i,
  input  wire logic [IdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]  cfg_data_i,
  output int unsigned           pending_o,
  output int unsigned           fail_count_o
);

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             repl;
    logic             cut;
    logic             last;
  } unit_exp_t;

  unit_exp_t        exp_units[$];
  logic             swap_q;
  logic [UnitW-1:0] repl_q;
  logic [UnitW-1:0] acc_q;
  logic [CntW-1:0]  left_q;
  logic [CntW-1:0]  size_q;

  function automatic logic [CntW-1:0] lead_length(input logic [7:0] b);
    casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      8'b111110??: return 3'd5;
      8'b1111110?: return 3'd6;
      default:     return 3'd0;
    endcase
  endfunction

  function automatic logic [UnitW-1:0] byte_order(input logic [UnitW-1:0] u);
    return swap_q ? {u[7:0], u[15:8]} : u;
  endfunction

  task automatic add_unit(input logic [UnitW-1:0] u, input logic repl, input logic cut,
                          input logic last);
    unit_exp_t e;
    e.unit = byte_order(u);
    e.repl = repl;
    e.cut  = cut;
    e.last = last;
    exp_units.push_back(e);
  endtask

  task automatic close_seq();
    acc_q  = '0;
    left_q = '0;
    size_q = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic [CntW-1:0]  n;
    logic [UnitW-1:0] acc_n;
    if (left_q == '0) begin
      n = lead_length(b);
      if (n == 3'd0) begin
        add_unit(repl_q, 1'b1, 1'b0, eot);
      end else if (n == 3'd1) begin
        add_unit({8'h00, b}, 1'b0, 1'b0, eot);
      end else if (eot) begin
        close_seq();
        add_unit('0, 1'b0, 1'b1, 1'b1);
      end else begin
        acc_q  = {8'h00, b};
        size_q = n;
        left_q = n - 3'd1;
      end
    end else begin
      acc_n  = {acc_q[9:0], b[5:0]};
      left_q = left_q - 3'd1;
      if (left_q == '0) begin
        if (size_q == 3'd2) acc_n = acc_n & 16'h07FF;
        close_seq();
        add_unit(acc_n, 1'b0, 1'b0, eot);
      end else if (eot) begin
        close_seq();
        add_unit('0, 1'b0, 1'b1, 1'b1);
      end else begin
        acc_q = acc_n;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    unit_exp_t want;
    if (!rst_ni) begin
      swap_q = 1'b0;
      repl_q = 16'h003F;
      close_seq();
      exp_units.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgSwapBytes) swap_q = cfg_data_i[0];
        else if (cfg_idx_i == CfgReplUnit) repl_q = cfg_data_i[UnitW-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (exp_units.size() == 0) begin
          $error("unexpected result: code_unit %h tuser %b tlast %b",
                 out_data_i, out_user_i, out_last_i);
          fail_count_o++;
        end else begin
          want = exp_units.pop_front();
          if (out_data_i !== want.unit) begin
            $error("code_unit: expected %h, got %h", want.unit, out_data_i);
            fail_count_o++;
          end
          if (out_user_i[0] !== want.repl) begin
            $error("was_replaced: expected %b, got %b", want.repl, out_user_i[0]);
            fail_count_o++;
          end
          if (out_user_i[1] !== want.cut) begin
            $error("cut_short: expected %b, got %b", want.cut, out_user_i[1]);
            fail_count_o++;
          end
          if (out_last_i !== want.last) begin
            $error("last_unit: expected %b, got %b", want.last, out_last_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_byte(in_data_i, in_last_i);
    end
    pending_o = exp_units.size();
  end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// stimulus for the utf-8 to 16-bit code unit decoder: a directed run over
// the lead byte classes but the five-byte one, truncated and cut-short sequences, then random
// phases of mostly well-formed sequences under changing register settings,
// with random idling on both sides and one long receiver hold
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import u8u16_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseItems  = 250;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned SettleCycles = 4;

  logic             clk;
  logic             rst_n;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;
  logic             s_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [15:0]      m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tlast;
  logic             cfg_we;
  logic [IdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]  cfg_data;
  int unsigned      pending;
  int unsigned      fail_count;
  int unsigned      cycles;
  logic             idle_on;
  logic             hold_req;
  logic             hold_done;

  // {end_of_text, byte}
  logic [8:0] directed_seq [25] = '{
    9'h000, 9'h07F, 9'h080, 9'h0FE, 9'h0FF,
    9'h0DF, 9'h0BF,
    9'h0E2, 9'h082, 9'h0AC,
    9'h0F0, 9'h09F, 9'h098, 9'h080,
    9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
    9'h0C2, 9'h041,
    9'h0E2, 9'h182,
    9'h1C5
  };

  utf8_to_utf16_decoder_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  u8u16_unit_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .out_last_i   (m_axis_tlast),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // unit receiver
  initial begin
    m_axis_tready = 1'b0;
    hold_done     = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eot);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_regs(input logic swap, input logic [15:0] repl);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgSwapBytes;
    cfg_data <= {{(CfgW-1){1'b0}}, swap};
    @(negedge clk);
    cfg_idx  <= CfgReplUnit;
    cfg_data <= repl;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic text_end();
    return $urandom_range(0, 29) == 0;
  endfunction

  // mostly well-formed sequences with random payload, some noise bytes
  task automatic send_random(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    logic [7:0]  b;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        push_byte(8'($urandom_range(0, 255)), text_end());
        sent++;
      end else begin
        r = $urandom_range(0, 15);
        if (r < 5) len = 1;
        else if (r < 9) len = 2;
        else if (r < 12) len = 3;
        else if (r < 14) len = 4;
        else if (r == 14) len = 5;
        else len = 6;
        case (len)
          1: b = 8'($urandom_range(0, 127));
          2: b = 8'hC0 | 8'($urandom_range(0, 31));
          3: b = 8'hE0 | 8'($urandom_range(0, 15));
          4: b = 8'hF0 | 8'($urandom_range(0, 7));
          5: b = 8'hF8 | 8'($urandom_range(0, 3));
          default: b = 8'hFC | 8'($urandom_range(0, 1));
        endcase
        push_byte(b, text_end());
        for (int unsigned k = 1; k < len; k++) begin
          if ($urandom_range(0, 15) == 0) b = 8'($urandom_range(0, 255));
          else b = 8'h80 | 8'($urandom_range(0, 63));
          push_byte(b, text_end());
        end
        sent += len;
      end
    end
  endtask

  initial begin
    logic [15:0] repl;
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CfgSwapBytes;
    cfg_data      = '0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_seq[i]) push_byte(directed_seq[i][7:0], directed_seq[i][8]);
    wait_idle();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: repl = 16'hFFFF;
        1: repl = 16'h0000;
        4: repl = ReplUnitReset;
        5: repl = 16'h8001;
        default: repl = 16'($urandom);
      endcase
      set_regs(ph[0] == 1'b0, repl);
      if (ph == 1) hold_req = 1'b1;
      if (ph == NumPhases - 1) idle_on = 1'b0;
      send_random(PhaseItems);
      // closes any open sequence
      push_byte(8'h20, 1'b1);
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_in_stage.sv
rtl/core/u8u16_core.sv
rtl/core/u8u16_out_stage.sv
rtl/core/utf8_to_utf16_decoder_unit.sv
dv/u8u16_unit_checker.sv
dv/tb.sv
